// ===== design/cmosrtc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the CMOS clock register file.
package cmosrtc_pkg;

	// RAM geometry
	localparam int RAM_DEPTH = 256;
	localparam int RAM_AW    = $clog2(RAM_DEPTH);

	// Stream widths
	localparam int IN_TDATA_W  = 48;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 8;

	// Configuration port
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;
	localparam logic CFG_KIND = 1'b0;
	localparam logic CFG_FOLD = 1'b1;

	// Access kinds carried on tuser
	localparam logic [1:0] OP_SET_ADDR = 2'd0;
	localparam logic [1:0] OP_WRITE    = 2'd1;
	localparam logic [1:0] OP_READ     = 2'd2;

	// Register map
	localparam logic [7:0] ADDR_SEC  = 8'd0;
	localparam logic [7:0] ADDR_MIN  = 8'd2;
	localparam logic [7:0] ADDR_HOUR = 8'd4;
	localparam logic [7:0] ADDR_WDAY = 8'd6;
	localparam logic [7:0] ADDR_DAY  = 8'd7;
	localparam logic [7:0] ADDR_MON  = 8'd8;
	localparam logic [7:0] ADDR_YEAR = 8'd9;
	localparam logic [7:0] ADDR_REGA = 8'd10;
	localparam logic [7:0] ADDR_REGB = 8'd11;
	localparam logic [7:0] ADDR_REGC = 8'd12;
	localparam logic [7:0] ADDR_REGD = 8'd13;

	// Addresses 0, 2, 4, 6, 7, 8, 9 and 12 sample the host time
	localparam logic [31:0] TIME_REG_MASK = 32'h0000_13D5;

	localparam logic [7:0] REGA_FIXED  = 8'h20;
	localparam logic [7:0] REGC_UF     = 8'h10;
	localparam logic [7:0] REGD_FIXED  = 8'h80;
	localparam logic [7:0] FOLD_MASK   = 8'h3F;

	// Controller to datapath commands
	typedef struct packed {
		logic take;      // an input transaction completes this cycle
		logic load_out;  // compose the read result into the output register
	} ctl_cmd_t;

	// One unpacked input item
	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] data;
		logic       refresh_due;
		logic [5:0] now_second;
		logic [5:0] now_minute;
		logic [4:0] now_hour;
		logic [2:0] now_weekday;
		logic [4:0] now_day;
		logic [3:0] now_month;
		logic [6:0] now_year;
	} in_item_t;

	function automatic logic is_time_reg(input logic [7:0] addr);
		logic res;
		res = (addr < 8'd32) && TIME_REG_MASK[addr[4:0]];
		return res;
	endfunction

	// Two BCD digits; tens by reciprocal multiply (exact below 1029), then mod 10
	function automatic logic [7:0] to_bcd(input logic [6:0] v);
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [3:0]  tens_m;
		logic [6:0]  ones;
		prod   = 15'(v) * 15'd205;
		tens   = prod[14:11];
		ones   = v - 7'(7'(tens) * 7'd10);
		tens_m = (tens >= 4'd10) ? tens - 4'd10 : tens;
		return {tens_m, ones[3:0]};
	endfunction

	function automatic logic [7:0] time_code(input logic [6:0] v, input logic binary);
		logic [7:0] res;
		res = binary ? {1'b0, v} : to_bcd(v);
		return res;
	endfunction

	function automatic logic [6:0] year_mod100(input logic [6:0] y);
		logic [6:0] res;
		res = (y >= 7'd100) ? y - 7'd100 : y;
		return res;
	endfunction

	// 1 + ((weekday + 8 - kind) mod 7); the sum stays within 5..15
	function automatic logic [7:0] weekday_code(input logic [2:0] wd, input logic [1:0] kind);
		logic [3:0] x;
		logic [3:0] m;
		x = {1'b0, wd} + 4'd8 - {2'b00, kind};
		if (x >= 4'd14) begin
			m = x - 4'd14;
		end else if (x >= 4'd7) begin
			m = x - 4'd7;
		end else begin
			m = x;
		end
		return {5'b0, m[2:0]} + 8'd1;
	endfunction

endpackage

// ===== design/cmosrtc_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences each access and owns the output valid flag.
module cmosrtc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [1:0]            operation,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output cmosrtc_pkg::ctl_cmd_t cmd
);
	import cmosrtc_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RD   = 1'b1;

	logic state_q;
	logic state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free     = !out_valid_q || m_tready;
	assign s_tready     = (state_q == ST_IDLE);
	assign m_tvalid     = out_valid_q;
	assign cmd.take     = s_tvalid && s_tready;
	assign cmd.load_out = (state_q == ST_RD) && out_free;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.take && operation == OP_READ) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Output register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_read_goes_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && operation == OP_READ) |=> (state_q == ST_RD))
		else $error("read transaction did not enter the read state");
	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("loaded result not presented");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !cmd.load_out)
		else $error("pending result overwritten");
`endif

endmodule

// ===== design/cmosrtc_dpath.sv =====
`timescale 1ns / 1ps
// Datapath: address latch, CMOS RAM, time snapshot, flags and read mux.
module cmosrtc_dpath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmosrtc_pkg::ctl_cmd_t cmd,
	input  cmosrtc_pkg::in_item_t item,
	input  logic [1:0]            cmos_kind,
	input  logic                  fold_to_64,
	output logic [7:0]            read_data
);
	import cmosrtc_pkg::*;

	logic [7:0]         ram_q [RAM_DEPTH];
	logic [RAM_DEPTH-1:0] ram_vld_q;
	logic [7:0]         reg_address_q;
	logic [3:0]         rega_low_q;
	logic               regb_bin_q;
	logic [5:0]         snap_second_q;
	logic [5:0]         snap_minute_q;
	logic [4:0]         snap_hour_q;
	logic [2:0]         snap_weekday_q;
	logic [4:0]         snap_day_q;
	logic [3:0]         snap_month_q;
	logic [6:0]         snap_year_q;
	logic [5:0]         last_second_q;
	logic               update_flag_q;
	logic               snap_valid_q;
	logic [7:0]         rd_addr_s1;
	logic [7:0]         rd_data_s1;
	logic               rd_vld_s1;
	logic               rd_flag_s1;
	logic [7:0]         read_data_q;

	logic [7:0]        addr;
	logic [RAM_AW-1:0] idx;
	logic              do_write;
	logic              do_read;
	logic              refresh;
	logic              flag_set;
	logic              flag_now;
	logic [7:0]        result;

	assign addr     = fold_to_64 ? (reg_address_q & FOLD_MASK) : reg_address_q;
	assign idx      = addr[RAM_AW-1:0];
	assign do_write = cmd.take && item.operation == OP_WRITE;
	assign do_read  = cmd.take && item.operation == OP_READ;
	assign refresh  = is_time_reg(addr) && (!snap_valid_q || item.refresh_due);
	assign flag_set = refresh && (item.now_second != last_second_q);
	assign flag_now = update_flag_q || flag_set;
	assign read_data = read_data_q;

	// RAM array: one write or one read per transaction
	always_ff @(posedge clk) begin
		if (do_write) begin
			ram_q[idx] <= item.data;
		end
		if (do_read) begin
			rd_data_s1 <= ram_q[idx];
			rd_addr_s1 <= addr;
			rd_flag_s1 <= flag_now;
		end
	end

	// Entry valid bits stand in for the clear at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_vld_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (do_write) begin
				ram_vld_q[idx] <= 1'b1;
			end
			if (do_read) begin
				rd_vld_s1 <= ram_vld_q[idx];
			end
		end
	end

	// Address latch and copies of the control bits of registers A and B
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_address_q <= '0;
			rega_low_q    <= '0;
			regb_bin_q    <= 1'b0;
		end else if (cmd.take) begin
			unique case (item.operation)
				OP_SET_ADDR: reg_address_q <= item.data;
				OP_WRITE: begin
					if (idx == RAM_AW'(ADDR_REGA)) begin
						rega_low_q <= item.data[3:0];
					end
					if (idx == RAM_AW'(ADDR_REGB)) begin
						regb_bin_q <= item.data[2];
					end
				end
				default: ;
			endcase
		end
	end

	// Time snapshot and update-ended flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_second_q  <= '0;
			snap_minute_q  <= '0;
			snap_hour_q    <= '0;
			snap_weekday_q <= '0;
			snap_day_q     <= '0;
			snap_month_q   <= 4'd1;
			snap_year_q    <= '0;
			last_second_q  <= '0;
			update_flag_q  <= 1'b0;
			snap_valid_q   <= 1'b0;
		end else if (do_read) begin
			if (refresh) begin
				snap_valid_q   <= 1'b1;
				snap_second_q  <= item.now_second;
				snap_minute_q  <= item.now_minute;
				snap_hour_q    <= item.now_hour;
				snap_weekday_q <= item.now_weekday;
				snap_day_q     <= item.now_day;
				snap_month_q   <= item.now_month;
				snap_year_q    <= item.now_year;
			end
			if (flag_set) begin
				last_second_q <= item.now_second;
			end
			// reading register C hands the flag over and clears it
			update_flag_q <= (addr == ADDR_REGC) ? 1'b0 : flag_now;
		end
	end

	// Read mux
	always_comb begin
		unique case (rd_addr_s1)
			ADDR_SEC:  result = time_code({1'b0, snap_second_q}, regb_bin_q);
			ADDR_MIN:  result = time_code({1'b0, snap_minute_q}, regb_bin_q);
			ADDR_HOUR: result = time_code({2'b0, snap_hour_q}, regb_bin_q);
			ADDR_WDAY: result = weekday_code(snap_weekday_q, cmos_kind);
			ADDR_DAY:  result = time_code({2'b0, snap_day_q}, regb_bin_q);
			ADDR_MON:  result = time_code({3'b0, snap_month_q}, regb_bin_q);
			ADDR_YEAR: result = time_code(year_mod100(snap_year_q), regb_bin_q);
			ADDR_REGA: result = REGA_FIXED | {4'b0, rega_low_q};
			ADDR_REGB: result = {5'b0, regb_bin_q, 2'b10};
			ADDR_REGC: result = rd_flag_s1 ? REGC_UF : 8'h00;
			ADDR_REGD: result = REGD_FIXED;
			default:   result = rd_vld_s1 ? rd_data_s1 : 8'h00;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			read_data_q <= result;
		end
	end

`ifndef SYNTHESIS
	a_regc_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(do_read && addr == ADDR_REGC) |=> !update_flag_q)
		else $error("update flag survived a register C read");
	a_refresh_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(do_read && refresh) |=> (snap_valid_q && snap_second_q == last_second_q))
		else $error("snapshot and last second disagree after refresh");
	a_write_marks: assert property (@(posedge clk) disable iff (!arst_n)
		do_write |=> ram_vld_q[$past(idx)])
		else $error("written entry not marked valid");
`endif

endmodule

// ===== design/cmos_rtc_register_file_top.sv =====
`timescale 1ns / 1ps
// Top level of the CMOS clock register file: stream ports, APB registers, submodules.
//
// Usage:
//   Input stream s_*: one bus access per transaction. s_tuser carries the access
//   kind (set address, write, read); s_tdata carries the byte and the host time.
//   Output stream m_*: one byte per read access, none for other kinds.
//   APB port: register 0 (byte 0) is the chip type code, register 1 (byte 4)
//   selects 64-byte address folding. Write only while no access is in flight.
// Timing:
//   Set-address and write accesses are taken while no read is pending; a new one can
//   follow every cycle then. On a read, the accept edge registers the RAM byte and
//   the read address; the read state then waits for a free output register and
//   builds the result into it, which raises m_tvalid. No access is taken while a
//   read sits in the read state, so a read is loaded before the next access is taken.
// Reset:
//   arst_n clears the address latch, the snapshot, the flags and every RAM
//   entry's valid bit at once, so the RAM reads as zero right after reset.
// Stall:
//   While m_tready is low a pending result holds; a following read waits in the
//   read state and s_tready stays low until the result register frees up.
module cmos_rtc_register_file_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [7:0] data, [8] refresh_due, [14:9] now_second, [20:15] now_minute,
	// [25:21] now_hour, [28:26] now_weekday, [33:29] now_day,
	// [37:34] now_month, [44:38] now_year, [47:45] zero
	input  logic [cmosrtc_pkg::IN_TDATA_W-1:0]  s_tdata,
	// [1:0] operation
	input  logic [cmosrtc_pkg::IN_TUSER_W-1:0]  s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [7:0] read_data
	output logic [cmosrtc_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [cmosrtc_pkg::CFG_AW-1:0]      paddr,
	input  logic [cmosrtc_pkg::CFG_DW-1:0]      pwdata,
	output logic [cmosrtc_pkg::CFG_DW-1:0]      prdata,
	output logic                                pready
);
	import cmosrtc_pkg::*;

	logic [1:0] cmos_kind_q;
	logic       fold_to_64_q;
	logic       cfg_wr;
	ctl_cmd_t   cmd;
	in_item_t   item;

	// Unpack the input transaction
	assign item.operation   = s_tuser;
	assign item.data        = s_tdata[7:0];
	assign item.refresh_due = s_tdata[8];
	assign item.now_second  = s_tdata[14:9];
	assign item.now_minute  = s_tdata[20:15];
	assign item.now_hour    = s_tdata[25:21];
	assign item.now_weekday = s_tdata[28:26];
	assign item.now_day     = s_tdata[33:29];
	assign item.now_month   = s_tdata[37:34];
	assign item.now_year    = s_tdata[44:38];

	// APB configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmos_kind_q  <= '0;
			fold_to_64_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				CFG_KIND: cmos_kind_q  <= pwdata[1:0];
				CFG_FOLD: fold_to_64_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			CFG_KIND: prdata = {{(CFG_DW-2){1'b0}}, cmos_kind_q};
			CFG_FOLD: prdata = {{(CFG_DW-1){1'b0}}, fold_to_64_q};
			default:  prdata = '0;
		endcase
	end

	cmosrtc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.operation (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cmd       (cmd)
	);

	cmosrtc_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.item       (item),
		.cmos_kind  (cmos_kind_q),
		.fold_to_64 (fold_to_64_q),
		.read_data  (m_tdata)
	);

endmodule

// ===== tb/cmos_rtc_checker.sv =====
`timescale 1ns / 1ps
// Checker for the CMOS clock register file: snoops the stream and APB ports, predicts and compares.
module cmos_rtc_checker
	import cmosrtc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	// [7:0] data, [8] refresh_due, [14:9] now_second, [20:15] now_minute,
	// [25:21] now_hour, [28:26] now_weekday, [33:29] now_day,
	// [37:34] now_month, [44:38] now_year, [47:45] zero
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// [1:0] operation
	input  logic [IN_TUSER_W-1:0]  s_tuser,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	// [7:0] read_data
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [CFG_AW-1:0]      paddr,
	input  logic [CFG_DW-1:0]      pwdata,
	input  logic                   pready,
	output int                     outstanding,
	output int                     errors
);

	// Shadow copy of the chip state
	logic [7:0] shadow_ram [0:RAM_DEPTH-1];
	logic [7:0] addr_latch;
	logic [5:0] snap_sec;
	logic [5:0] snap_min;
	logic [4:0] snap_hour;
	logic [2:0] snap_wday;
	logic [4:0] snap_day;
	logic [3:0] snap_month;
	logic [6:0] snap_year;
	logic [5:0] prev_sec;
	logic       update_pending;
	logic       snap_taken;
	logic [1:0] chip_kind;
	logic       fold_on;

	logic [7:0] read_bytes [$];
	int         mismatch_cnt;

	// Time value as BCD, or binary when register B bit 2 is set
	function automatic logic [7:0] clock_byte(input int unsigned v);
		if (shadow_ram[ADDR_REGB][2]) begin
			return 8'(v);
		end
		return 8'((v % 10) + 16 * ((v / 10) % 10));
	endfunction

	function automatic logic samples_clock(input logic [7:0] a);
		case (a)
			ADDR_SEC, ADDR_MIN, ADDR_HOUR, ADDR_WDAY, ADDR_DAY, ADDR_MON, ADDR_YEAR,
			ADDR_REGC: return 1'b1;
			default:   return 1'b0;
		endcase
	endfunction

	task automatic log_mismatch(input string what, input logic [7:0] want, input logic [7:0] got);
		mismatch_cnt++;
		if (mismatch_cnt <= 10) begin
			$display("%0t: %s: read_data expected %02h got %02h", $realtime, what, want, got);
		end
	endtask

	// Apply one bus access to the shadow state; a read queues its byte
	task automatic model_access(input logic [1:0] op, input logic [IN_TDATA_W-1:0] td);
		logic [7:0] a;
		logic [7:0] r;
		a = fold_on ? (addr_latch & FOLD_MASK) : addr_latch;
		case (op)
			OP_SET_ADDR: addr_latch = td[7:0];
			OP_WRITE:    shadow_ram[a] = td[7:0];
			OP_READ: begin
				if (samples_clock(a) && (!snap_taken || td[8])) begin
					snap_taken = 1'b1;
					snap_sec   = td[14:9];
					snap_min   = td[20:15];
					snap_hour  = td[25:21];
					snap_wday  = td[28:26];
					snap_day   = td[33:29];
					snap_month = td[37:34];
					snap_year  = td[44:38];
					if (snap_sec != prev_sec) begin
						update_pending = 1'b1;
						prev_sec = snap_sec;
					end
				end
				case (a)
					ADDR_SEC:  r = clock_byte(snap_sec);
					ADDR_MIN:  r = clock_byte(snap_min);
					ADDR_HOUR: r = clock_byte(snap_hour);
					ADDR_WDAY: r = 8'(1 + (int'(snap_wday) + 8 - int'(chip_kind)) % 7);
					ADDR_DAY:  r = clock_byte(snap_day);
					ADDR_MON:  r = clock_byte(snap_month);
					ADDR_YEAR: r = clock_byte(int'(snap_year) % 100);
					ADDR_REGA: r = REGA_FIXED | (shadow_ram[ADDR_REGA] & 8'h0F);
					ADDR_REGB: r = (shadow_ram[ADDR_REGB] & 8'h04) | 8'h02;
					ADDR_REGC: begin
						r = update_pending ? REGC_UF : 8'h00;
						update_pending = 1'b0;
					end
					ADDR_REGD: r = REGD_FIXED;
					default:   r = shadow_ram[a];
				endcase
				read_bytes.push_back(r);
			end
			default: ;  // unused code: no effect
		endcase
	endtask

	// Snoop all three ports each edge; results are matched before new accesses are queued
	always @(posedge clk or negedge arst_n) begin
		logic [7:0] want;
		if (!arst_n) begin
			for (int i = 0; i < RAM_DEPTH; i++) begin
				shadow_ram[i] = 8'h00;
			end
			addr_latch     = 8'h00;
			snap_sec       = '0;
			snap_min       = '0;
			snap_hour      = '0;
			snap_wday      = '0;
			snap_day       = '0;
			snap_month     = 4'd1;
			snap_year      = '0;
			prev_sec       = '0;
			update_pending = 1'b0;
			snap_taken     = 1'b0;
			chip_kind      = 2'd0;
			fold_on        = 1'b0;
			read_bytes.delete();
			mismatch_cnt   = 0;
			outstanding   <= 0;
			errors        <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == {CFG_KIND, 2'b00}) begin
					chip_kind = pwdata[1:0];
				end else if (paddr == {CFG_FOLD, 2'b00}) begin
					fold_on = pwdata[0];
				end
			end
			if (m_tvalid && m_tready) begin
				if (read_bytes.size() == 0) begin
					log_mismatch("unexpected transaction", 8'h00, m_tdata);
				end else begin
					want = read_bytes.pop_front();
					if (want !== m_tdata) begin
						log_mismatch("wrong byte", want, m_tdata);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				model_access(s_tuser, s_tdata);
			end
			outstanding <= read_bytes.size();
			errors      <= mismatch_cnt;
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the CMOS clock register file: clock, reset, stimulus and verdict.
module tb_top;
	import cmosrtc_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int         PHASES    = 8;
	localparam int         PER_PHASE = 80;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	// [7:0] data, [8] refresh_due, [14:9] now_second, [20:15] now_minute,
	// [25:21] now_hour, [28:26] now_weekday, [33:29] now_day,
	// [37:34] now_month, [44:38] now_year, [47:45] zero
	logic [IN_TDATA_W-1:0]  s_tdata;
	// [1:0] operation
	logic [IN_TUSER_W-1:0]  s_tuser;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// [7:0] read_data
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [CFG_AW-1:0]      paddr;
	logic [CFG_DW-1:0]      pwdata;
	logic [CFG_DW-1:0]      prdata;
	logic                   pready;

	int outstanding;
	int errors;

	// Per-phase idling, in percent
	int gap_pct   = 0;
	int stall_pct = 0;

	// Host time presented with each access
	in_item_t host_clock;

	int phase_kind [PHASES] = '{3, 0, 1, 2, 0, 3, 2, 1};
	int phase_fold [PHASES] = '{0, 1, 0, 1, 1, 0, 0, 1};
	int phase_gap  [4]      = '{0, 56, 0, 27};
	int phase_stall[4]      = '{0, 0, 56, 27};

	cmos_rtc_register_file_top uut (.*);

	cmos_rtc_checker checker_i (.*);

	always #10 clk = ~clk;

	// Receiver back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Run limit
	initial begin
		#10_000_000;
		$display("tb_top: errors");
		$finish;
	end

	// One access transaction on the input stream, with an optional gap first
	task automatic bus(input logic [1:0] op, input logic [7:0] dat, input logic refresh);
		int n;
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			n = $urandom_range(3, 1);
			repeat (n) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {3'b000, host_clock.now_year, host_clock.now_month, host_clock.now_day,
			host_clock.now_weekday, host_clock.now_hour, host_clock.now_minute,
			host_clock.now_second, refresh, dat};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic apb_write(input logic [CFG_AW-1:0] a, input logic [CFG_DW-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= a;
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Drain outstanding reads, then give the last write time to land
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// About half the calls take a new host time: mostly in range, sometimes anything the widths allow
	task automatic tick_clock();
		if ($urandom_range(99) < 50) begin
			return;
		end
		if ($urandom_range(99) < 85) begin
			host_clock.now_second  = 6'($urandom_range(60));
			host_clock.now_minute  = 6'($urandom_range(59));
			host_clock.now_hour    = 5'($urandom_range(23));
			host_clock.now_weekday = 3'($urandom_range(6));
			host_clock.now_day     = 5'($urandom_range(31, 1));
			host_clock.now_month   = 4'($urandom_range(12, 1));
			host_clock.now_year    = 7'($urandom_range(99));
		end else begin
			host_clock.now_second  = 6'($urandom);
			host_clock.now_minute  = 6'($urandom);
			host_clock.now_hour    = 5'($urandom);
			host_clock.now_weekday = 3'($urandom);
			host_clock.now_day     = 5'($urandom);
			host_clock.now_month   = 4'($urandom);
			host_clock.now_year    = 7'($urandom);
		end
	endtask

	// Mostly the clock registers, then the fold window, then anywhere
	function automatic logic [7:0] pick_address();
		int r;
		r = $urandom_range(99);
		if (r < 50) begin
			return 8'($urandom_range(ADDR_REGD));
		end else if (r < 75) begin
			return 8'($urandom_range(FOLD_MASK));
		end
		return 8'($urandom);
	endfunction

	initial begin
		int sent;
		int n;
		logic [1:0] op;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = OP_SET_ADDR;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		host_clock = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int p = 0; p < PHASES; p++) begin
			apb_write({CFG_KIND, 2'b00}, CFG_DW'(phase_kind[p]));
			apb_write({CFG_FOLD, 2'b00}, CFG_DW'(phase_fold[p]));
			gap_pct   = phase_gap[p % 4];
			stall_pct = phase_stall[p % 4];

			if (p == 0) begin
				// Directed: top of range, first-read snapshot, flag read and clear
				host_clock = '{OP_READ, 8'h00, 1'b0, 6'd59, 6'd59, 5'd23, 3'd6, 5'd31,
					4'd12, 7'd99};
				bus(OP_SET_ADDR, ADDR_SEC, 1'b0);
				bus(OP_READ, 8'h00, 1'b0);
				bus(OP_SET_ADDR, ADDR_REGC, 1'b0);
				bus(OP_READ, 8'h00, 1'b0);
				bus(OP_READ, 8'h00, 1'b0);
				bus(OP_SET_ADDR, ADDR_REGD, 1'b0);
				bus(OP_READ, 8'h00, 1'b0);
				bus(OP_SET_ADDR, ADDR_REGA, 1'b0);
				bus(OP_WRITE, 8'hFF, 1'b0);
				bus(OP_READ, 8'h00, 1'b0);
				bus(OP_SET_ADDR, ADDR_REGB, 1'b0);
				bus(OP_WRITE, 8'hFF, 1'b0);
				bus(OP_READ, 8'h00, 1'b0);
				// Every field at full width, binary mode, year above 99
				host_clock = '{OP_READ, 8'h00, 1'b0, 6'd63, 6'd63, 5'd31, 3'd7, 5'd31,
					4'd15, 7'd127};
				bus(OP_SET_ADDR, ADDR_YEAR, 1'b0);
				bus(OP_READ, 8'h00, 1'b1);
				bus(OP_SET_ADDR, ADDR_WDAY, 1'b0);
				bus(OP_READ, 8'h00, 1'b0);
				// Back to BCD: second above 59
				bus(OP_SET_ADDR, ADDR_REGB, 1'b0);
				bus(OP_WRITE, 8'h00, 1'b0);
				bus(OP_SET_ADDR, ADDR_SEC, 1'b0);
				bus(OP_READ, 8'h00, 1'b1);
				// Top of RAM, the unused code, first non-clock address
				bus(OP_SET_ADDR, 8'hFF, 1'b0);
				bus(OP_WRITE, 8'hA5, 1'b0);
				bus(OP_READ, 8'h00, 1'b0);
				bus(OP_UNUSED, 8'hFF, 1'b1);
				bus(OP_SET_ADDR, 8'd32, 1'b0);
				bus(OP_READ, 8'h00, 1'b0);
				bus(OP_SET_ADDR, 8'd1, 1'b0);
				bus(OP_READ, 8'h00, 1'b0);
			end

			// Random: mostly address-then-accesses sequences, some noise
			sent = 0;
			while (sent < PER_PHASE) begin
				if ($urandom_range(99) < 75) begin
					tick_clock();
					bus(OP_SET_ADDR, pick_address(), 1'($urandom));
					sent++;
					n = $urandom_range(4, 1);
					repeat (n) begin
						tick_clock();
						if ($urandom_range(99) < 60) begin
							bus(OP_READ, 8'($urandom), ($urandom_range(99) < 40));
						end else begin
							bus(OP_WRITE, 8'($urandom), 1'($urandom));
						end
						sent++;
					end
				end else begin
					tick_clock();
					op = 2'($urandom);
					bus(op, 8'($urandom), 1'($urandom));
					if (op != OP_UNUSED) begin
						sent++;
					end
				end
			end
			settle();
		end

		repeat (8) @(posedge clk);
		if (errors == 0 && outstanding == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/cmosrtc_pkg.sv
design/cmosrtc_ctrl.sv
design/cmosrtc_dpath.sv
design/cmos_rtc_register_file_top.sv
tb/cmos_rtc_checker.sv
tb/tb_top.sv
